[rtl/terminal_line_editor_top_assert.svh]
// assertion macros for the line editor rtl, included by tle_core
// expects signals clk and rst_n in the including module
`ifndef TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define TLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tle_pkg.sv]
// line editor package: beat structs, command and kind codes, fsm types
// no dependencies
`default_nettype none

package tle_pkg;

  localparam int POS_W  = 6;
  localparam int CHAR_W = 8;
  localparam int CMD_W  = 4;
  localparam int KIND_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CHAR   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LEFT   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_WLEFT  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_WRIGHT = 4'd4;
  localparam logic [CMD_W-1:0] CMD_HOME   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_END    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_BKSP   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DEL    = 4'd8;
  localparam logic [CMD_W-1:0] CMD_ENTER  = 4'd9;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EOL    = 2'd2;

  // separator after reset
  localparam logic [CHAR_W-1:0] SEP_RESET = 8'd32;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] key_char;
  } tle_in_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] out_char;
    logic [POS_W-1:0]  cursor_pos;
    logic [POS_W-1:0]  line_length;
    logic              ignored;
    logic              last;
  } tle_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } tle_state_t;

  // what the scan engine does with each read
  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_SHR,
    MODE_SHL,
    MODE_WLEFT,
    MODE_WRIGHT,
    MODE_ENTER
  } tle_mode_t;

endpackage

`default_nettype wire

[rtl/tle_ram.sv]
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[rtl/tle_core.sv]
// line editor sequencer: command decode, shift/scan engine over the line ram,
// result register; uses tle_pkg and the assertion macro header
`default_nettype none
`include "terminal_line_editor_top_assert.svh"

module tle_core #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire tle_pkg::tle_in_t      in_data,
  input  wire logic [7:0]            sep,
  output logic                       out_valid,
  output tle_pkg::tle_out_t          out_data,
  output logic                       ram_we,
  output logic [$clog2(LINE_CAPACITY)-1:0] ram_waddr,
  output logic [7:0]                 ram_wdata,
  output logic [$clog2(LINE_CAPACITY)-1:0] ram_raddr,
  input  wire logic [7:0]            ram_rdata
);

  import tle_pkg::*;

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam logic [POS_W-1:0] FULL_LEN = POS_W'(LINE_CAPACITY - 1);

  tle_state_t        state_r, state_nxt;
  tle_mode_t         mode_r, mode_nxt;
  logic [POS_W-1:0]  cur_r, cur_nxt;
  logic [POS_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  res_cur_r, res_cur_nxt;
  logic [POS_W-1:0]  res_len_r, res_len_nxt;
  logic              ign_r, ign_nxt;
  logic [CHAR_W-1:0] key_r, key_nxt;
  logic [POS_W-1:0]  rp_r, rp_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic              p_valid_r, p_valid_nxt;
  logic [POS_W-1:0]  p_pos_r, p_pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  tle_out_t          out_data_r, out_data_nxt;

  logic              issue;
  logic              descend;
  logic [POS_W-1:0]  cur_inc, cur_dec, p_pos_inc, p_pos_dec;

  assign cur_inc   = cur_r + 6'd1;
  assign cur_dec   = cur_r - 6'd1;
  assign p_pos_inc = p_pos_r + 6'd1;
  assign p_pos_dec = p_pos_r - 6'd1;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // reads go one per cycle while the count lasts
  assign issue     = (state_r == ST_SCAN) && (cnt_r != '0);
  assign descend   = (mode_r == MODE_SHR) || (mode_r == MODE_WLEFT);
  assign ram_raddr = rp_r[AW-1:0];

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_NONE;
      cur_r       <= '0;
      len_r       <= '0;
      cnt_r       <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cur_r       <= cur_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_cur_r  <= res_cur_nxt;
    res_len_r  <= res_len_nxt;
    ign_r      <= ign_nxt;
    key_r      <= key_nxt;
    rp_r       <= rp_nxt;
    p_pos_r    <= p_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  // decode, scan engine and result generation
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cur_nxt       = cur_r;
    len_nxt       = len_r;
    res_cur_nxt   = res_cur_r;
    res_len_nxt   = res_len_r;
    ign_nxt       = ign_r;
    key_nxt       = key_r;
    rp_nxt        = rp_r;
    cnt_nxt       = cnt_r;
    p_valid_nxt   = issue;
    p_pos_nxt     = rp_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = p_pos_r[AW-1:0];
    ram_wdata     = ram_rdata;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt     = in_data.key_char;
          mode_nxt    = MODE_NONE;
          res_cur_nxt = cur_r;
          res_len_nxt = len_r;
          ign_nxt     = 1'b0;
          cnt_nxt     = '0;
          rp_nxt      = '0;
          case (in_data.cmd)
            CMD_CHAR: begin
              if (len_r >= FULL_LEN) begin
                ign_nxt = 1'b1;
              end else begin
                // tail moves right from the end down to the cursor
                mode_nxt    = MODE_SHR;
                cnt_nxt     = len_r - cur_r;
                rp_nxt      = len_r - 6'd1;
                res_cur_nxt = cur_inc;
                res_len_nxt = len_r + 6'd1;
              end
            end
            CMD_LEFT: begin
              if (cur_r != '0) begin
                res_cur_nxt = cur_dec;
              end
            end
            CMD_RIGHT: begin
              if (cur_r < len_r) begin
                res_cur_nxt = cur_inc;
              end
            end
            CMD_WLEFT: begin
              if (cur_r != '0) begin
                // scan left of the stepped cursor for a separator
                mode_nxt    = MODE_WLEFT;
                cnt_nxt     = cur_dec;
                rp_nxt      = cur_r - 6'd2;
                res_cur_nxt = '0;
              end
            end
            CMD_WRIGHT: begin
              res_cur_nxt = len_r;
              if ((cur_r != len_r) && (cur_inc != len_r)) begin
                mode_nxt = MODE_WRIGHT;
                cnt_nxt  = len_r - cur_inc;
                rp_nxt   = cur_inc;
              end
            end
            CMD_HOME: begin
              res_cur_nxt = '0;
            end
            CMD_END: begin
              res_cur_nxt = len_r;
            end
            CMD_BKSP: begin
              if (cur_r == '0) begin
                ign_nxt = 1'b1;
              end else begin
                mode_nxt    = MODE_SHL;
                cnt_nxt     = len_r - cur_r;
                rp_nxt      = cur_r;
                res_cur_nxt = cur_dec;
                res_len_nxt = len_r - 6'd1;
              end
            end
            CMD_DEL: begin
              if (cur_r >= len_r) begin
                ign_nxt = 1'b1;
              end else begin
                mode_nxt    = MODE_SHL;
                cnt_nxt     = len_r - cur_inc;
                rp_nxt      = cur_inc;
                res_len_nxt = len_r - 6'd1;
              end
            end
            CMD_ENTER: begin
              mode_nxt    = MODE_ENTER;
              cnt_nxt     = len_r;
              rp_nxt      = '0;
              res_cur_nxt = '0;
              res_len_nxt = '0;
            end
            default: begin
              mode_nxt = MODE_NONE;
            end
          endcase
          state_nxt = (cnt_nxt != '0) ? ST_SCAN : ST_DONE;
        end
      end

      ST_SCAN: begin
        // advance the read pointer
        if (issue) begin
          cnt_nxt = cnt_r - 6'd1;
          rp_nxt  = descend ? (rp_r - 6'd1) : (rp_r + 6'd1);
        end
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
        // act on the data read in the previous cycle
        if (p_valid_r) begin
          case (mode_r)
            MODE_SHR: begin
              ram_we    = 1'b1;
              ram_waddr = p_pos_inc[AW-1:0];
            end
            MODE_SHL: begin
              ram_we    = 1'b1;
              ram_waddr = p_pos_dec[AW-1:0];
            end
            MODE_WLEFT: begin
              if (ram_rdata == sep) begin
                res_cur_nxt = p_pos_inc;
                state_nxt   = ST_DONE;
                p_valid_nxt = 1'b0;
              end
            end
            MODE_WRIGHT: begin
              if (ram_rdata == sep) begin
                res_cur_nxt = p_pos_r;
                state_nxt   = ST_DONE;
                p_valid_nxt = 1'b0;
              end
            end
            MODE_ENTER: begin
              out_valid_nxt            = 1'b1;
              out_data_nxt.kind        = KIND_CHAR;
              out_data_nxt.out_char    = ram_rdata;
              out_data_nxt.cursor_pos  = '0;
              out_data_nxt.line_length = '0;
              out_data_nxt.ignored     = 1'b0;
              out_data_nxt.last        = 1'b0;
            end
            default: begin
              ram_we = 1'b0;
            end
          endcase
        end
      end

      ST_DONE: begin
        // insert drops the key into the opened slot
        if (mode_r == MODE_SHR) begin
          ram_we    = 1'b1;
          ram_waddr = cur_r[AW-1:0];
          ram_wdata = key_r;
        end
        p_valid_nxt              = 1'b0;
        out_valid_nxt            = 1'b1;
        out_data_nxt.kind        = (mode_r == MODE_ENTER) ? KIND_EOL : KIND_STATUS;
        out_data_nxt.out_char    = '0;
        out_data_nxt.cursor_pos  = res_cur_r;
        out_data_nxt.line_length = res_len_r;
        out_data_nxt.ignored     = ign_r;
        out_data_nxt.last        = 1'b1;
        cur_nxt                  = res_cur_r;
        len_nxt                  = res_len_r;
        state_nxt                = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // checks on the sequencer
  `TLE_ASSERT_NOW(a_cur_in_line, 1'b1, cur_r <= len_r, "cursor beyond line end")
  `TLE_ASSERT_NOW(a_len_fits, 1'b1, len_r <= FULL_LEN, "line longer than capacity")
  `TLE_ASSERT_NOW(a_we_busy, ram_we, state_r != ST_IDLE, "ram write while idle")
  `TLE_ASSERT_NEXT(a_accept_quiet, start && !busy, !out_valid_r, "result right after accept")
  `TLE_ASSERT_NEXT(a_done_last, state_r == ST_DONE, out_valid_r && out_data_r.last,
    "final beat missing")

endmodule

`default_nettype wire

[rtl/terminal_line_editor_top.sv]
// line editor top: separator register, sequencer and line ram
// uses tle_pkg, tle_core and tle_ram
`default_nettype none

// Line editor with one text line of up to LINE_CAPACITY-1 characters held in
// a single-port-read ram. A key beat is taken when start is high and busy is
// low. Cursor moves, home and end go from accept straight to the done state,
// which registers their status beat. Insert, backspace, delete and word moves
// shift or scan the line one character per cycle through the ram read port,
// then pass to the done state for their status beat. Enter streams the line
// out at one character beat per cycle, then an end-of-line beat marked last.
// Every result beat is shown on out_data for one cycle with out_valid high;
// the receiver cannot stall, so it must take each beat as it comes. The next
// key can be taken at the edge that takes the final beat. The separator
// register is written on cfg_valid and cfg_ready, and cfg_ready is high only
// while no key is in progress.
module terminal_line_editor_top #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire tle_pkg::tle_in_t  in_data,
  output logic                   out_valid,
  output tle_pkg::tle_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data
);

  import tle_pkg::*;

  localparam int AW = $clog2(LINE_CAPACITY);

  logic [CHAR_W-1:0] sep_r, sep_nxt;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  // separator register
  assign cfg_ready = !busy;
  assign sep_nxt   = (cfg_valid && cfg_ready) ? cfg_data : sep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else begin
      sep_r <= sep_nxt;
    end
  end

  // sequencer
  tle_core #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .sep       (sep_r),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // line storage
  tle_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(LINE_CAPACITY)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

[tb/tb_terminal_line_editor_top.sv]
// self-checking bench for terminal_line_editor_top: keys in, status and line beats out
// depends on tle_pkg and terminal_line_editor_top; a shadow line editor predicts every beat
`default_nettype none

module tb_terminal_line_editor_top;
  import tle_pkg::*;

  localparam int LINE_CAP       = 64;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = LINE_CAP + 8;
  localparam int KEYS_PER_PHASE = 12;
  localparam int PRINT_CAP      = 40;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd10;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  tle_in_t   in_data;
  logic      out_valid;
  tle_out_t  out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [7:0] cfg_data;

  // shadow editor state
  logic [CHAR_W-1:0] line_q [LINE_CAP];
  int                cur_q;
  int                len_q;
  logic [CHAR_W-1:0] sep_q;

  tle_out_t pending_beats[$];
  int       err_count   = 0;
  int       cycle_count = 0;
  bit       calm        = 1'b0;

  typedef struct {
    tle_in_t  key;
    bit       typed;
    tle_out_t beat;
  } key_row_t;

  key_row_t key_table[$];

  terminal_line_editor_top #(.LINE_CAPACITY(LINE_CAP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle count and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("terminal_line_editor_top verification failed");
      $finish;
    end
  end

  task automatic flag(string msg);
    if (err_count < PRINT_CAP) $display("ERROR cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic tle_in_t mk_key(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch);
    tle_in_t k;
    k.cmd      = cmd;
    k.key_char = ch;
    return k;
  endfunction

  function automatic tle_out_t status_beat(int cur, int len, bit ign);
    tle_out_t b;
    b.kind        = KIND_STATUS;
    b.out_char    = '0;
    b.cursor_pos  = POS_W'(cur);
    b.line_length = POS_W'(len);
    b.ignored     = ign;
    b.last        = 1'b1;
    return b;
  endfunction

  function automatic tle_out_t eol_beat();
    tle_out_t b;
    b      = '0;
    b.kind = KIND_EOL;
    b.last = 1'b1;
    return b;
  endfunction

  // shadow editor: apply one key, queue the beats it should produce
  function automatic void edit_line(tle_in_t key);
    int       i;
    bit       ign;
    tle_out_t b;
    ign = 1'b0;
    case (key.cmd)
      CMD_CHAR: begin
        if (len_q >= LINE_CAP - 1) begin
          ign = 1'b1;
        end else begin
          for (i = len_q; i > cur_q; i--) line_q[i] = line_q[i-1];
          line_q[cur_q] = key.key_char;
          cur_q++;
          len_q++;
        end
      end
      CMD_LEFT: begin
        if (cur_q > 0) cur_q--;
      end
      CMD_RIGHT: begin
        if (cur_q < len_q) cur_q++;
      end
      CMD_WLEFT: begin
        if (cur_q > 0) begin
          cur_q--;
          while (cur_q > 0 && line_q[cur_q-1] != sep_q) cur_q--;
        end
      end
      CMD_WRIGHT: begin
        cur_q++;
        while (cur_q < len_q && line_q[cur_q] != sep_q) cur_q++;
        if (cur_q > len_q) cur_q = len_q;
      end
      CMD_HOME: cur_q = 0;
      CMD_END:  cur_q = len_q;
      CMD_BKSP: begin
        if (cur_q == 0) begin
          ign = 1'b1;
        end else begin
          for (i = cur_q; i < len_q; i++) line_q[i-1] = line_q[i];
          cur_q--;
          len_q--;
        end
      end
      CMD_DEL: begin
        if (cur_q >= len_q) begin
          ign = 1'b1;
        end else begin
          for (i = cur_q; i + 1 < len_q; i++) line_q[i] = line_q[i+1];
          len_q--;
        end
      end
      CMD_ENTER: begin
        // stream the line, then end of line, then clear
        for (i = 0; i < len_q; i++) begin
          b          = '0;
          b.kind     = KIND_CHAR;
          b.out_char = line_q[i];
          pending_beats.push_back(b);
        end
        pending_beats.push_back(eol_beat());
        cur_q = 0;
        len_q = 0;
        return;
      end
      default: ;
    endcase
    pending_beats.push_back(status_beat(cur_q, len_q, ign));
  endfunction

  // inserts are the most common key, mostly from a small alphabet plus the separator, so words form
  function automatic tle_in_t random_key();
    int                r;
    logic [CHAR_W-1:0] ch;
    r  = $urandom_range(0, 99);
    ch = CHAR_W'($urandom_range(0, 255));
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0:       ch = sep_q;
        1:       ;
        default: ch = CHAR_W'(8'h61 + $urandom_range(0, 3));
      endcase
      return mk_key(CMD_CHAR, ch);
    end
    if (r < 46) return mk_key(CMD_LEFT, ch);
    if (r < 52) return mk_key(CMD_RIGHT, ch);
    if (r < 59) return mk_key(CMD_WLEFT, ch);
    if (r < 66) return mk_key(CMD_WRIGHT, ch);
    if (r < 71) return mk_key(CMD_HOME, ch);
    if (r < 76) return mk_key(CMD_END, ch);
    if (r < 85) return mk_key(CMD_BKSP, ch);
    if (r < 93) return mk_key(CMD_DEL, ch);
    if (r < 97) return mk_key(CMD_ENTER, ch);
    return mk_key(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), ch);
  endfunction

  // send one key beat, with an occasional idle gap first
  task automatic press_key(tle_in_t key);
    while (!calm && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= key;
    do @(posedge clk); while (busy);
    edit_line(key);
  endtask

  // hold keys off until every queued beat has come back
  task automatic settle();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_separator(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sep_q = v;
  endtask

  // fill to capacity at scattered positions, push past full, edit, commit
  task automatic fill_line();
    int n;
    while (len_q < LINE_CAP - 1) begin
      if ($urandom_range(0, 7) == 0) press_key(mk_key(CMD_LEFT, 8'h00));
      else press_key(mk_key(CMD_CHAR, CHAR_W'($urandom_range(0, 255))));
    end
    for (n = 0; n < 3; n++) press_key(mk_key(CMD_CHAR, CHAR_W'($urandom_range(0, 255))));
    press_key(mk_key(CMD_END, 8'h00));
    press_key(mk_key(CMD_WLEFT, 8'h00));
    press_key(mk_key(CMD_WRIGHT, 8'h00));
    press_key(mk_key(CMD_HOME, 8'h00));
    press_key(mk_key(CMD_DEL, 8'h00));
    press_key(mk_key(CMD_CHAR, 8'h7e));
    press_key(mk_key(CMD_CHAR, 8'h7f));
    press_key(mk_key(CMD_END, 8'h00));
    press_key(mk_key(CMD_BKSP, 8'h00));
    press_key(mk_key(CMD_ENTER, 8'h00));
  endtask

  task automatic add_row(tle_in_t key, bit typed, tle_out_t beat);
    key_row_t row;
    row.key   = key;
    row.typed = typed;
    row.beat  = beat;
    key_table.push_back(row);
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : beat_check
    tle_out_t want;
    if (rst_n && out_valid) begin
      if (pending_beats.size() == 0) begin
        flag($sformatf("unexpected beat %h", out_data));
      end else begin
        want = pending_beats.pop_front();
        if (out_data.kind != want.kind)
          flag($sformatf("kind got %0d want %0d", out_data.kind, want.kind));
        if (out_data.out_char != want.out_char)
          flag($sformatf("out_char got %0h want %0h", out_data.out_char, want.out_char));
        if (out_data.cursor_pos != want.cursor_pos)
          flag($sformatf("cursor_pos got %0d want %0d", out_data.cursor_pos, want.cursor_pos));
        if (out_data.line_length != want.line_length)
          flag($sformatf("line_length got %0d want %0d", out_data.line_length,
                         want.line_length));
        if (out_data.ignored != want.ignored)
          flag($sformatf("ignored got %0b want %0b", out_data.ignored, want.ignored));
        if (out_data.last != want.last)
          flag($sformatf("last got %0b want %0b", out_data.last, want.last));
      end
    end
  end

  initial begin : stimulus
    int         p;
    int         n;
    logic [7:0] sep_plan [4];
    tle_out_t   none;

    none      = '0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;

    foreach (line_q[i]) line_q[i] = '0;
    cur_q = 0;
    len_q = 0;
    sep_q = SEP_RESET;

    // empty line corners, spare codes, extreme characters, word moves
    add_row(mk_key(CMD_LEFT, 8'h00), 1, status_beat(0, 0, 0));
    add_row(mk_key(CMD_BKSP, 8'h00), 1, status_beat(0, 0, 1));
    add_row(mk_key(CMD_DEL, 8'h00), 1, status_beat(0, 0, 1));
    add_row(mk_key(CMD_WLEFT, 8'h00), 1, status_beat(0, 0, 0));
    add_row(mk_key(CMD_WRIGHT, 8'h00), 1, status_beat(0, 0, 0));
    add_row(mk_key(CMD_ENTER, 8'h00), 1, eol_beat());
    add_row(mk_key(CMD_SPARE_LO, 8'hff), 1, status_beat(0, 0, 0));
    add_row(mk_key(CMD_SPARE_HI, 8'h5a), 1, status_beat(0, 0, 0));
    add_row(mk_key(CMD_CHAR, 8'h00), 1, status_beat(1, 1, 0));
    add_row(mk_key(CMD_CHAR, 8'hff), 1, status_beat(2, 2, 0));
    add_row(mk_key(CMD_CHAR, 8'h61), 0, none);
    add_row(mk_key(CMD_CHAR, 8'h20), 0, none);
    add_row(mk_key(CMD_CHAR, 8'h62), 0, none);
    add_row(mk_key(CMD_HOME, 8'h00), 1, status_beat(0, 5, 0));
    add_row(mk_key(CMD_WRIGHT, 8'h00), 0, none);
    add_row(mk_key(CMD_WRIGHT, 8'h00), 0, none);
    add_row(mk_key(CMD_WLEFT, 8'h00), 0, none);
    add_row(mk_key(CMD_END, 8'h00), 1, status_beat(5, 5, 0));
    add_row(mk_key(CMD_RIGHT, 8'h00), 1, status_beat(5, 5, 0));
    add_row(mk_key(CMD_DEL, 8'h00), 1, status_beat(5, 5, 1));
    add_row(mk_key(CMD_LEFT, 8'h00), 0, none);
    add_row(mk_key(CMD_LEFT, 8'h00), 0, none);
    add_row(mk_key(CMD_BKSP, 8'h00), 0, none);
    add_row(mk_key(CMD_DEL, 8'h00), 0, none);
    add_row(mk_key(CMD_ENTER, 8'h00), 0, none);

    sep_plan[0] = 8'h00;
    sep_plan[1] = 8'hff;
    sep_plan[2] = 8'($urandom_range(0, 255));
    sep_plan[3] = SEP_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows; typed rows replace the predicted beat
    foreach (key_table[i]) begin
      press_key(key_table[i].key);
      if (key_table[i].typed) pending_beats[pending_beats.size()-1] = key_table[i].beat;
    end
    settle();

    // random phases, one separator setting each; phase 2 and the fill run without gaps
    for (p = 0; p < 4; p++) begin
      write_separator(sep_plan[p]);
      calm = (p == 2);
      for (n = 0; n < KEYS_PER_PHASE; n++) press_key(random_key());
      if (p == 2) fill_line();
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0) flag("expected beats never arrived");

    if (err_count == 0) begin
      $display("terminal_line_editor_top verification clean");
    end else begin
      $display("terminal_line_editor_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
